// ===== rtl/ncc_pkg.sv =====
// Shared constants, reference color tables and helper functions for the
// nearest color class matcher. No dependencies.
package ncc_pkg;

    localparam int NUM_CLASSES    = 6;
    localparam int BODY_SUM_WIDTH = 24;

    localparam int TABLE_SIZE = 16;
    localparam int MARK_W     = 20;
    localparam int REF_W      = 20;
    localparam int TOTAL_W    = MARK_W + 2;
    localparam int BLUE20_W   = MARK_W + 5;
    localparam int ABS_W      = (BODY_SUM_WIDTH > REF_W) ? BODY_SUM_WIDTH : REF_W;
    localparam int DIST_W     = 26;
    localparam int SUM_W      = (ABS_W + 2 > DIST_W) ? ABS_W + 2 : DIST_W;
    localparam int CLASS_W    = 3;
    localparam int IDX_W      = (NUM_CLASSES > 2) ? $clog2(NUM_CLASSES) : 1;
    localparam int NUM_PAIRS  = (NUM_CLASSES + 1) / 2;

    typedef logic [REF_W-1:0] ref_tab_t [TABLE_SIZE];

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } chan_t;

    localparam ref_tab_t NORM_R = '{0: 20'd885748, 1: 20'd293783, 2: 20'd300391,
                                    3: 20'd607459, 4: 20'd835587, 5: 20'd868031,
                                    default: 20'd0};
    localparam ref_tab_t NORM_G = '{0: 20'd377968, 1: 20'd651749, 2: 20'd624135,
                                    3: 20'd309999, 4: 20'd775478, 5: 20'd296616,
                                    default: 20'd0};
    localparam ref_tab_t NORM_B = '{0: 20'd308418, 1: 20'd417185, 2: 20'd860149,
                                    3: 20'd658677, 4: 20'd320619, 5: 20'd631009,
                                    default: 20'd0};
    localparam ref_tab_t ENH_R  = '{0: 20'd895791, 1: 20'd591046, 2: 20'd313007,
                                    3: 20'd758484, 4: 20'd928395, 5: 20'd961682,
                                    default: 20'd0};
    localparam ref_tab_t ENH_G  = '{0: 20'd425218, 1: 20'd846944, 2: 20'd631362,
                                    3: 20'd484856, 4: 20'd897501, 5: 20'd460849,
                                    default: 20'd0};
    localparam ref_tab_t ENH_B  = '{0: 20'd352430, 1: 20'd703509, 2: 20'd847330,
                                    3: 20'd805604, 4: 20'd569245, 5: 20'd785462,
                                    default: 20'd0};

    function automatic logic [REF_W-1:0] ref_min3(input logic [REF_W-1:0] a,
                                                  input logic [REF_W-1:0] b,
                                                  input logic [REF_W-1:0] c);
        logic [REF_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    // Reference channel for class k; enhanced entries have their smallest
    // channel already removed.
    function automatic logic [REF_W-1:0] ref_value(input int unsigned k,
                                                   input chan_t ch,
                                                   input logic enh);
        logic [REF_W-1:0] base;
        logic [REF_W-1:0] floor_v;
        floor_v = ref_min3(ENH_R[k], ENH_G[k], ENH_B[k]);
        case (ch)
            CH_RED:   base = enh ? ENH_R[k] : NORM_R[k];
            CH_GREEN: base = enh ? ENH_G[k] : NORM_G[k];
            CH_BLUE:  base = enh ? ENH_B[k] : NORM_B[k];
            default:  base = '0;
        endcase
        return enh ? (base - floor_v) : base;
    endfunction

endpackage

// ===== rtl/nearest_color_class_matcher_top.sv =====
// Nearest color class matcher: six-stage pipeline, L1 nearest reference.
// Depends on ncc_pkg (tables, widths, helper functions).
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------
//   in      | to block  | in_valid/in_stall  | mark_*_sum (20b), body_*_sum (24b)
//   out     | from block| out_valid/out_stall| class_index, is_enhanced, best_distance
//
// One beat enters per cycle while the output is not stalled. The depth is
// set by the chain enhance test, channel floor subtract, per-class abs
// difference, per-class sum and a two-level min search, one stage each.
// Reset clears only the stage valid bits; payload registers carry no reset.
// A stall on the output freezes the whole pipeline in place and raises
// in_stall in the same cycle, so no beat is dropped or repeated.
module nearest_color_class_matcher_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ncc_pkg::MARK_W-1:0]          mark_red_sum,
    input  logic [ncc_pkg::MARK_W-1:0]          mark_green_sum,
    input  logic [ncc_pkg::MARK_W-1:0]          mark_blue_sum,
    input  logic [ncc_pkg::BODY_SUM_WIDTH-1:0]  body_red_sum,
    input  logic [ncc_pkg::BODY_SUM_WIDTH-1:0]  body_green_sum,
    input  logic [ncc_pkg::BODY_SUM_WIDTH-1:0]  body_blue_sum,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ncc_pkg::CLASS_W-1:0]         class_index,
    output logic                                is_enhanced,
    output logic [ncc_pkg::DIST_W-1:0]          best_distance
);

    localparam int BW = ncc_pkg::BODY_SUM_WIDTH;
    localparam int AW = ncc_pkg::ABS_W;
    localparam int SW = ncc_pkg::SUM_W;
    localparam int IW = ncc_pkg::IDX_W;
    localparam int NC = ncc_pkg::NUM_CLASSES;
    localparam int NP = ncc_pkg::NUM_PAIRS;

    // Whole pipeline advances unless a finished beat sits stalled at the output.
    logic advance;
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    // Stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: enhance test on the marker sums, floor of the body sums
    // ---------------------------------------------------------------
    logic [ncc_pkg::TOTAL_W-1:0]  total;
    logic [ncc_pkg::BLUE20_W-1:0] blue_ext;
    logic [ncc_pkg::BLUE20_W-1:0] blue20;
    logic                         enh1_next;
    logic [BW-1:0]                min_rg;
    logic [BW-1:0]                floor1_next;

    always_comb
    begin
        total = ncc_pkg::TOTAL_W'(mark_red_sum) + ncc_pkg::TOTAL_W'(mark_green_sum)
              + ncc_pkg::TOTAL_W'(mark_blue_sum);
        blue_ext = ncc_pkg::BLUE20_W'(mark_blue_sum);
        // Times 20 as times 16 plus times 4
        blue20 = (blue_ext << 4) + (blue_ext << 2);
        // A zero total never counts as enhanced.
        enh1_next = (total != '0) && (blue20 < ncc_pkg::BLUE20_W'(total));
        min_rg = (body_red_sum < body_green_sum) ? body_red_sum : body_green_sum;
        floor1_next = (min_rg < body_blue_sum) ? min_rg : body_blue_sum;
    end

    logic          enh1_reg;
    logic [BW-1:0] floor1_reg;
    logic [BW-1:0] r1_reg, g1_reg, b1_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            enh1_reg   <= enh1_next;
            floor1_reg <= floor1_next;
            r1_reg     <= body_red_sum;
            g1_reg     <= body_green_sum;
            b1_reg     <= body_blue_sum;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: drop the smallest channel for enhanced cells
    // ---------------------------------------------------------------
    logic [AW-1:0] r2_next, g2_next, b2_next;

    always_comb
    begin
        r2_next = AW'(enh1_reg ? (r1_reg - floor1_reg) : r1_reg);
        g2_next = AW'(enh1_reg ? (g1_reg - floor1_reg) : g1_reg);
        b2_next = AW'(enh1_reg ? (b1_reg - floor1_reg) : b1_reg);
    end

    logic          enh2_reg;
    logic [AW-1:0] r2_reg, g2_reg, b2_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            enh2_reg <= enh1_reg;
            r2_reg   <= r2_next;
            g2_reg   <= g2_next;
            b2_reg   <= b2_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: per-class, per-channel absolute differences
    // ---------------------------------------------------------------
    logic [AW-1:0] adr3_next [NC];
    logic [AW-1:0] adg3_next [NC];
    logic [AW-1:0] adb3_next [NC];

    always_comb
    begin
        logic [AW-1:0] rr, rg, rb;
        for (int k = 0; k < NC; k++)
        begin
            rr = AW'(ncc_pkg::ref_value(k, ncc_pkg::CH_RED,   enh2_reg));
            rg = AW'(ncc_pkg::ref_value(k, ncc_pkg::CH_GREEN, enh2_reg));
            rb = AW'(ncc_pkg::ref_value(k, ncc_pkg::CH_BLUE,  enh2_reg));
            adr3_next[k] = (r2_reg >= rr) ? (r2_reg - rr) : (rr - r2_reg);
            adg3_next[k] = (g2_reg >= rg) ? (g2_reg - rg) : (rg - g2_reg);
            adb3_next[k] = (b2_reg >= rb) ? (b2_reg - rb) : (rb - b2_reg);
        end
    end

    logic          enh3_reg;
    logic [AW-1:0] adr3_reg [NC];
    logic [AW-1:0] adg3_reg [NC];
    logic [AW-1:0] adb3_reg [NC];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            enh3_reg <= enh2_reg;
            adr3_reg <= adr3_next;
            adg3_reg <= adg3_next;
            adb3_reg <= adb3_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: L1 distance per class
    // ---------------------------------------------------------------
    logic [SW-1:0] dist4_next [NC];

    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            dist4_next[k] = SW'(adr3_reg[k]) + SW'(adg3_reg[k]) + SW'(adb3_reg[k]);
        end
    end

    logic          enh4_reg;
    logic [SW-1:0] dist4_reg [NC];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            enh4_reg  <= enh3_reg;
            dist4_reg <= dist4_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: first min level over neighboring class pairs
    // ---------------------------------------------------------------
    logic [SW-1:0] pd5_next [NP];
    logic [IW-1:0] pi5_next [NP];

    always_comb
    begin
        for (int p = 0; p < NP; p++)
        begin
            pd5_next[p] = dist4_reg[2*p];
            pi5_next[p] = IW'(2*p);
            // Odd class takes over only when strictly closer: lower index wins ties.
            if (2*p + 1 < NC)
            begin
                if (dist4_reg[2*p+1] < dist4_reg[2*p])
                begin
                    pd5_next[p] = dist4_reg[2*p+1];
                    pi5_next[p] = IW'(2*p + 1);
                end
            end
        end
    end

    logic          enh5_reg;
    logic [SW-1:0] pd5_reg [NP];
    logic [IW-1:0] pi5_reg [NP];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            enh5_reg <= enh4_reg;
            pd5_reg  <= pd5_next;
            pi5_reg  <= pi5_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: final min over the pair winners, into the output register
    // ---------------------------------------------------------------
    logic [SW-1:0]   best_d;
    logic [IW-1:0]   best_i;
    logic [IW+2:0]   idx_ext;
    logic [ncc_pkg::CLASS_W-1:0] class_index_next;
    logic [ncc_pkg::DIST_W-1:0]  best_distance_next;

    always_comb
    begin
        best_d = pd5_reg[0];
        best_i = pi5_reg[0];
        for (int p = 1; p < NP; p++)
        begin
            if (pd5_reg[p] < best_d)
            begin
                best_d = pd5_reg[p];
                best_i = pi5_reg[p];
            end
        end
        idx_ext            = (IW + 3)'(best_i);
        class_index_next   = idx_ext[ncc_pkg::CLASS_W-1:0];
        best_distance_next = best_d[ncc_pkg::DIST_W-1:0];
    end

    logic                         is_enhanced_reg;
    logic [ncc_pkg::CLASS_W-1:0]  class_index_reg;
    logic [ncc_pkg::DIST_W-1:0]   best_distance_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            is_enhanced_reg   <= enh5_reg;
            class_index_reg   <= class_index_next;
            best_distance_reg <= best_distance_next;
        end
    end

    assign out_valid     = v6_reg;
    assign class_index   = class_index_reg;
    assign is_enhanced   = is_enhanced_reg;
    assign best_distance = best_distance_reg;

endmodule

// ===== rtl/ncc_checker.sv =====
// Port-level checks for the nearest color class matcher, bound to the top.
// Depends on ncc_pkg and nearest_color_class_matcher_top.
module ncc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic [ncc_pkg::MARK_W-1:0]          mark_red_sum,
    input logic [ncc_pkg::MARK_W-1:0]          mark_green_sum,
    input logic [ncc_pkg::MARK_W-1:0]          mark_blue_sum,
    input logic [ncc_pkg::BODY_SUM_WIDTH-1:0]  body_red_sum,
    input logic [ncc_pkg::BODY_SUM_WIDTH-1:0]  body_green_sum,
    input logic [ncc_pkg::BODY_SUM_WIDTH-1:0]  body_blue_sum,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [ncc_pkg::CLASS_W-1:0]         class_index,
    input logic                                is_enhanced,
    input logic [ncc_pkg::DIST_W-1:0]          best_distance
);

    // Hold a stalled result beat unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(class_index)
            && $stable(is_enhanced) && $stable(best_distance))
        else $error("stalled output beat changed");

    // Stall the input only behind a stalled result.
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // Keep the class index inside the reference table.
    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (class_index < ncc_pkg::CLASS_W'(ncc_pkg::NUM_CLASSES)))
        else $error("class index beyond the reference table");

    // Drop all result beats while in reset: the edge after reset is seen
    // shows an empty output.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result beat shown during reset");

endmodule

bind nearest_color_class_matcher_top ncc_checker u_ncc_checker (.*);
